>>> design/sidec_pkg.sv
// Shared constants and helpers for the signed integer to decimal ASCII unit.
// No dependencies; used by sidec_bcd_unit and signed_int_to_decimal_ascii_unit.
`default_nettype none

package sidec_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Add-3 correction of the shift-and-add-3 conversion.
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ       = 4'd3;

    // Decimal digits needed for any value below 2**bits (log10(2) ~ 0.30103).
    function automatic int dec_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

endpackage

`default_nettype wire

>>> design/sidec_bcd_unit.sv
// Iterative binary to BCD converter, one magnitude bit per cycle.
// Depends on sidec_pkg for the add-3 correction constants.
`default_nettype none

module sidec_bcd_unit #(
    parameter int VALUE_BITS = sidec_pkg::VALUE_BITS_DEFAULT,
    parameter int DIGITS     = sidec_pkg::dec_digits(VALUE_BITS),
    parameter int IDX_W      = $clog2(DIGITS)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [VALUE_BITS-1:0]         mag,
    output logic                               busy,
    output logic                               done,
    output logic [DIGITS-1:0][3:0]             bcd,
    output logic [IDX_W-1:0]                   lead_idx
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic [DIGITS-1:0][3:0]  bcd_reg, bcd_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [DIGITS-1:0][3:0]  adj;
    logic [DIGITS*4:0]       shifted;

    // Every digit that would overflow on doubling gets 3 added before the shift.
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= sidec_pkg::BCD_ADJ_LIMIT) ?
                     bcd_reg[i] + sidec_pkg::BCD_ADJ : bcd_reg[i];
        end
        shifted = {adj, mag_reg[VALUE_BITS-1]};
    end

    always_comb begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            mag_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_BITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = shifted[DIGITS*4-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Position of the most significant nonzero digit; zero gives position 0.
    always_comb begin
        lead_idx = '0;
        for (int i = 1; i < DIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign bcd  = bcd_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("conversion started while busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && cnt_reg == '0) |=> (done_reg && !busy_reg))
        else $error("conversion did not finish on the last bit");

endmodule

`default_nettype wire

>>> design/signed_int_to_decimal_ascii_unit.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sidec_pkg and sidec_bcd_unit.
//
// Each request carries one signed two's complement integer of VALUE_BITS bits.
// The block answers with its decimal text, one ASCII character per transfer on
// the result channel, most significant digit first, a minus sign ahead of a
// negative value, and m_last on the final character. Zero gives a single '0';
// the most negative value is converted through its unsigned magnitude. The
// conversion time is set by the shift-and-add-3 unit, which consumes one
// magnitude bit per cycle. s_ready stays low from the accepted request until
// the last character is taken.
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = sidec_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [VALUE_BITS-1:0]  s_value,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_ascii_char,
    output logic                        m_last
);

    localparam int DIGITS = sidec_pkg::dec_digits(VALUE_BITS);
    localparam int IDX_W  = $clog2(DIGITS);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_SIGN  = 4'b0100,
        ST_DIGIT = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    neg_reg, neg_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;

    logic                    in_fire;
    logic                    out_fire;
    logic [VALUE_BITS-1:0]   mag;
    logic                    conv_busy;
    logic                    conv_done;
    logic [DIGITS-1:0][3:0]  bcd;
    logic [IDX_W-1:0]        lead_idx;
    logic [3:0]              digit;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign mag      = s_value[VALUE_BITS-1] ? (~s_value + 1'b1) : s_value;

    sidec_bcd_unit #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS),
        .IDX_W      (IDX_W)
    ) u_bcd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_fire),
        .mag      (mag),
        .busy     (conv_busy),
        .done     (conv_done),
        .bcd      (bcd),
        .lead_idx (lead_idx)
    );

    always_comb begin
        state_next = state_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    neg_next   = s_value[VALUE_BITS-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    idx_next   = lead_idx;
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_fire) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_fire) begin
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        idx_reg <= idx_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign digit        = bcd[idx_reg];
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_SIGN) || (state_reg == ST_DIGIT);
    assign m_ascii_char = (state_reg == ST_SIGN) ? sidec_pkg::CHAR_MINUS :
                          sidec_pkg::CHAR_ZERO + {4'd0, digit};
    assign m_last       = (state_reg == ST_DIGIT) && (idx_reg == '0);

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input ready while a character is pending");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (!s_ready && conv_busy))
        else $error("request accepted without starting a conversion");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_last) |=> s_ready)
        else $error("block not ready after the last character");

    a_digit_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGIT) |->
            (m_ascii_char >= sidec_pkg::CHAR_ZERO && m_ascii_char <= sidec_pkg::CHAR_NINE))
        else $error("digit character out of range");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for signed_int_to_decimal_ascii_unit: random and directed integers in,
// decimal ASCII characters out, checked against an in-bench predictor.
// Depends on sidec_pkg and the unit under test only.
`timescale 1ns / 1ps

module tb_top;

    localparam int VB          = sidec_pkg::VALUE_BITS_DEFAULT;
    localparam int RANDOM_NUMS = 410;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [VB-1:0] s_value = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [7:0]    m_ascii_char;
    logic          m_last;

    logic [VB-1:0] pending_values[$];
    text_char_t    expected_chars[$];
    int            mismatches = 0;
    int            values_sent = 0;
    int            chars_seen = 0;
    int            quiet_cycles = 0;

    signed_int_to_decimal_ascii_unit #(
        .VALUE_BITS(VB)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ascii_char(m_ascii_char),
        .m_last      (m_last)
    );

    always #10 aclk = ~aclk;

    // Appends the decimal text of one accepted integer to the expected characters.
    function automatic void queue_decimal_text(input logic [VB-1:0] value);
        logic          negative;
        logic [VB-1:0] magnitude;
        logic [3:0]    digits[$];
        text_char_t    c;
        negative  = value[VB-1];
        magnitude = negative ? -value : value;
        do begin
            digits.push_front(4'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (negative) begin
            c.ch   = sidec_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        foreach (digits[i]) begin
            c.ch   = sidec_pkg::CHAR_ZERO + 8'(digits[i]);
            c.last = (i == digits.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d (character %0d)",
                 $realtime, what, want, got, chars_seen);
        mismatches++;
    endtask

    // Random integer: full range, small magnitudes, digit-count boundaries
    // around powers of ten, or a random bit length.
    function automatic logic [VB-1:0] pick_value();
        logic [VB-1:0] v;
        logic [VB-1:0] p;
        int            kind;
        kind = $urandom_range(0, 3);
        p    = 1;
        case (kind)
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: begin
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if (kind != 0 && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // Request driver: valid holds until the request is taken.
    always @(posedge aclk) begin
        logic hold;
        logic calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                queue_decimal_text(s_value);
                values_sent++;
            end
            hold = s_valid && !s_ready;
            calm = values_sent >= 150 && values_sent < 260;
            if (!hold) begin
                if (pending_values.size() > 0 && (calm || $urandom_range(0, 99) >= 14)) begin
                    s_value <= pending_values.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge aclk) begin
        text_char_t want;
        logic       calm;
        calm = chars_seen >= 1200 && chars_seen < 2300;
        m_ready <= calm || $urandom_range(0, 99) >= 14;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected character", 8'd0, m_ascii_char);
            end else begin
                want = expected_chars.pop_front();
                if (m_ascii_char !== want.ch)
                    report_mismatch("ascii_char", want.ch, m_ascii_char);
                if (m_last !== want.last)
                    report_mismatch("last", 8'(want.last), 8'(m_last));
            end
            chars_seen++;
        end
    end

    // Watchdog on cycles without any accepted request or character.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int         directed[];
        text_char_t missing;
        directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345,
                     999999999, 1000000000, -999999999, -1000000000,
                     123456789, -123456789, 2147483647, -2147483647,
                     int'(32'h8000_0000), int'(32'h5555_5555),
                     int'(32'hAAAA_AAAA)};
        foreach (directed[i])
            pending_values.push_back(VB'(directed[i]));
        repeat (RANDOM_NUMS)
            pending_values.push_back(pick_value());

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_values.size() > 0 || s_valid || expected_chars.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        // Any character still expected at this point never arrived.
        while (expected_chars.size() > 0) begin
            missing = expected_chars.pop_front();
            report_mismatch("missing character", missing.ch, 8'd0);
        end
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
